[hw/rtl/order_book_price_levels_assert.svh]
// assertion macros for the order book price levels block
`ifndef ORDER_BOOK_PRICE_LEVELS_ASSERT_SVH
`define ORDER_BOOK_PRICE_LEVELS_ASSERT_SVH

`define OBPL_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define OBPL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/obpl_pkg.sv]
package obpl_pkg;
	localparam int MaxLevels = 64;
	localparam int IdxW = $clog2(MaxLevels);
	localparam int CntW = $clog2(MaxLevels + 1);

	localparam logic [1:0] REQ_UPDATE = 2'd0;
	localparam logic [1:0] REQ_CLEAR  = 2'd1;
	localparam logic [1:0] REQ_VOLUME = 2'd2;
	localparam logic [1:0] REQ_VWAP   = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_THIN = 2'd2;

	localparam logic [37:0] VolMax = '1;

	typedef struct packed {
		logic [31:0] price;
		logic [31:0] size;
		logic [15:0] orders;
	} level_t;

	// request to the divider
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;
endpackage

[hw/rtl/obpl_side_mem.sv]
module obpl_side_mem import obpl_pkg::*; (
	input  logic            clk,
	input  logic            we,
	input  logic [IdxW-1:0] waddr,
	input  level_t          wdata,
	input  logic [IdxW-1:0] raddr,
	output level_t          rdata
);
	level_t mem [MaxLevels];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hw/rtl/obpl_divider.sv]
module obpl_divider import obpl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;

	assign trial = {rem_q[31:0], quo_q[63]} - {1'b0, den_q};
	assign rsp   = '{done: done_q, quo: quo_q};

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
				quo_q  <= req.num;
				rem_q  <= '0;
				den_q  <= req.den;
			end else if (busy_q) begin
				if (!rem_q[32] && (rem_q[31] || !trial[32])) begin
					rem_q <= {1'b0, trial[31:0]};
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= {rem_q[31:0], quo_q[63]};
					quo_q <= {quo_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

[hw/rtl/order_book_price_levels.sv]
// order book price levels: two sorted level tables, bids descending, asks ascending
// s_axis carries one request per transaction; m_axis returns one result per request
// s_axis_tdata: req_type, side, price, size, level_orders, depth (lowest bit up)
// m_axis_tdata: status, best_bid_price, best_ask_price, spread, mid_price_x2,
//   bid_level_count, ask_level_count, query_result (lowest bit up)
// one request is handled at a time; s_axis_tready is low while it is worked on
// a sequencer walks the table memories one entry at a time, reading each entry
// and then acting on it; update: binary search (read, then compare, per step) plus
// shifting and writing; volume: read and add per level summed; vwap: read, multiply
// and accumulate per level walked, then a division
// clear: only the level counts reset; every request ends by reading the top of book
// and loading the result
// reset empties both sides and drops any pending result
// the result waits in an output register while m_axis_tready is low; the next
// request may be taken while it waits, its result is held back until the slot frees
module order_book_price_levels import obpl_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [95:0]  s_axis_tdata,  // req_type, side, price, size, level_orders, depth
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [183:0] m_axis_tdata   // status, bb, ba, spread, mid2, bcnt, acnt, query
);
	typedef enum logic [3:0] {
		S_IDLE, S_SRD, S_SCMP, S_DECIDE, S_SHRD, S_SHWR, S_WRITE,
		S_VRD, S_VACC, S_WMUL, S_WACC, S_WDIV, S_TOPRD, S_TOPGET, S_DONE
	} state_t;

	state_t      state_q;
	logic [1:0]  req_q;
	logic        side_q;
	logic [31:0] price_q;
	logic [31:0] size_q;
	logic [15:0] ord_q;
	logic [CntW-1:0] used_q [2];
	logic [CntW-1:0] lo_q, hi_q, i_q, n_q;
	logic        wside_q;
	logic        found_q;
	logic [1:0]  status_q;
	logic [63:0] acc_q;
	logic [32:0] rem_q;
	logic [63:0] prod_s1;
	logic [31:0] fill_q;
	logic [31:0] bb_q, ba_q;
	logic        out_v_q;
	logic [183:0] out_q;

	logic            we [2];
	logic [IdxW-1:0] waddr, raddr;
	level_t          wdata;
	level_t          rdata [2];
	level_t          rd;
	logic [CntW-1:0] mid, cur_used;

	div_req_t dreq;
	div_rsp_t drsp;

	for (genvar g = 0; g < 2; g++) begin : g_side
		obpl_side_mem u_mem (
			.clk(clk), .we(we[g]), .waddr(waddr), .wdata(wdata),
			.raddr(raddr), .rdata(rdata[g])
		);
	end

	obpl_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign rd       = rdata[wside_q];
	assign cur_used = used_q[wside_q];
	assign mid      = lo_q + ((hi_q - lo_q) >> 1);

	// shared read address
	always_comb begin
		unique case (state_q)
			S_SRD:   raddr = mid[IdxW-1:0];
			S_TOPRD: raddr = '0;
			default: raddr = i_q[IdxW-1:0];
		endcase
	end

	logic better, found;
	assign better = side_q ? (rd.price < price_q) : (rd.price > price_q);
	assign found  = (lo_q < cur_used) && (rd.price == price_q);

	logic [31:0] rem_lo;
	assign rem_lo = rem_q[31:0];

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

	logic [32:0] spread;
	logic [32:0] mid2;
	logic        both;
	assign both   = (bb_q != '0) && (ba_q != '0);
	assign spread = both ? ({1'b0, ba_q} - {1'b0, bb_q}) : '0;
	assign mid2   = both ? ({1'b0, ba_q} + {1'b0, bb_q}) : '0;

	// shifting write, or final write of the level
	logic shift_wr;
	assign shift_wr = (state_q == S_SHWR);
	always_comb begin
		we[0] = 1'b0;
		we[1] = 1'b0;
		waddr = i_q[IdxW-1:0];
		wdata = '{price: price_q, size: size_q, orders: ord_q};
		if (shift_wr) begin
			we[wside_q] = 1'b1;
			wdata = rd;
			// delete moves i to i-1, insert moves i to i+1
			waddr = (size_q == '0) ? i_q[IdxW-1:0] - IdxW'(1) : i_q[IdxW-1:0] + IdxW'(1);
		end else if (state_q == S_WRITE) begin
			we[wside_q] = 1'b1;
			waddr = lo_q[IdxW-1:0];
		end
	end

	always_comb begin
		dreq.start = (state_q == S_WACC) && (rem_q == {1'b0, fill_q});
		dreq.num   = acc_q + prod_s1;
		dreq.den   = size_q;
	end

	logic [37:0] vsum;
	assign vsum = acc_q[37:0] + 38'(rd.size);

	logic [63:0] vwap_next;
	assign vwap_next = acc_q + prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			used_q[0] <= '0;
			used_q[1] <= '0;
			out_v_q   <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_v_q || m_axis_tready)) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						req_q    <= s_axis_tdata[1:0];
						side_q   <= s_axis_tdata[2];
						price_q  <= s_axis_tdata[34:3];
						size_q   <= s_axis_tdata[66:35];
						ord_q    <= s_axis_tdata[82:67];
						status_q <= ST_OK;
						acc_q    <= '0;
						i_q      <= '0;
						lo_q     <= '0;
						unique case (s_axis_tdata[1:0])
							REQ_UPDATE: begin
								wside_q <= s_axis_tdata[2];
								hi_q    <= used_q[s_axis_tdata[2]];
								state_q <= S_SRD;
							end
							REQ_CLEAR: begin
								used_q[0] <= '0;
								used_q[1] <= '0;
								state_q   <= S_TOPRD;
							end
							REQ_VOLUME: begin
								wside_q <= s_axis_tdata[2];
								n_q <= (s_axis_tdata[89:83] != '0 &&
									CntW'(s_axis_tdata[89:83]) < used_q[s_axis_tdata[2]])
									? CntW'(s_axis_tdata[89:83]) : used_q[s_axis_tdata[2]];
								state_q <= S_VRD;
							end
							default: begin
								wside_q <= !s_axis_tdata[2];
								rem_q   <= {1'b0, s_axis_tdata[66:35]};
								state_q <= (s_axis_tdata[66:35] == '0) ? S_TOPRD : S_VRD;
							end
						endcase
					end
				end
				S_SRD: begin
					state_q <= (lo_q < hi_q) ? S_SCMP : S_DECIDE;
				end
				S_SCMP: begin
					if (better) begin
						lo_q <= mid + CntW'(1);
					end else begin
						hi_q <= mid;
					end
					state_q <= S_SRD;
				end
				S_DECIDE: begin
					// memory now holds entry lo on the read port
					found_q <= found;
					if (found) begin
						if (size_q == '0) begin
							i_q     <= lo_q + CntW'(1);
							state_q <= S_SHRD;
						end else begin
							state_q <= S_WRITE;
						end
					end else if (size_q == '0) begin
						state_q <= S_TOPRD;
					end else if (cur_used >= CntW'(MaxLevels)) begin
						status_q <= ST_FULL;
						state_q  <= S_TOPRD;
					end else begin
						i_q     <= cur_used - CntW'(1);
						state_q <= (cur_used > lo_q) ? S_SHRD : S_WRITE;
					end
				end
				S_SHRD: begin
					if (size_q == '0 && i_q >= cur_used) begin
						used_q[wside_q] <= cur_used - CntW'(1);
						state_q <= S_TOPRD;
					end else begin
						state_q <= S_SHWR;
					end
				end
				S_SHWR: begin
					if (size_q == '0) begin
						i_q     <= i_q + CntW'(1);
						state_q <= S_SHRD;
					end else if (i_q == lo_q) begin
						state_q <= S_WRITE;
					end else begin
						i_q     <= i_q - CntW'(1);
						state_q <= S_SHRD;
					end
				end
				S_WRITE: begin
					if (!found_q) begin
						used_q[wside_q] <= cur_used + CntW'(1);
					end
					state_q <= S_TOPRD;
				end
				S_VRD: begin
					if (req_q == REQ_VOLUME) begin
						state_q <= (i_q < n_q) ? S_VACC : S_TOPRD;
					end else if (i_q < cur_used) begin
						state_q <= S_WMUL;
					end else begin
						status_q <= ST_THIN;
						acc_q    <= '0;
						state_q  <= S_TOPRD;
					end
				end
				S_VACC: begin
					acc_q   <= {26'd0, (vsum < acc_q[37:0]) ? VolMax : vsum};
					i_q     <= i_q + CntW'(1);
					state_q <= S_VRD;
				end
				S_WMUL: begin
					fill_q  <= (rd.size < rem_lo) ? rd.size : rem_lo;
					prod_s1 <= 64'(((rd.size < rem_lo) ? rd.size : rem_lo)) * 64'(rd.price);
					state_q <= S_WACC;
				end
				S_WACC: begin
					rem_q <= rem_q - {1'b0, fill_q};
					i_q   <= i_q + CntW'(1);
					if (rem_q == {1'b0, fill_q}) begin
						acc_q   <= vwap_next;
						state_q <= S_WDIV;
					end else if (i_q + CntW'(1) >= cur_used) begin
						status_q <= ST_THIN;
						acc_q    <= '0;
						state_q  <= S_TOPRD;
					end else begin
						acc_q   <= vwap_next;
						state_q <= S_VRD;
					end
				end
				S_WDIV: begin
					if (drsp.done) begin
						acc_q   <= drsp.quo;
						state_q <= S_TOPRD;
					end
				end
				S_TOPRD: begin
					state_q <= S_TOPGET;
				end
				S_TOPGET: begin
					bb_q    <= (used_q[0] != '0) ? rdata[0].price : '0;
					ba_q    <= (used_q[1] != '0) ? rdata[1].price : '0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_v_q || m_axis_tready) begin
						out_q   <= {(req_q[1] ? acc_q[37:0] : 38'd0),
							7'(used_q[1]), 7'(used_q[0]), mid2, spread,
							ba_q, bb_q, status_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`include "order_book_price_levels_assert.svh"

	`OBPL_ASSERT_IMPL(a_ready_idle, s_axis_tready, !m_axis_tvalid || state_q == S_IDLE, "ready outside idle")
	`OBPL_ASSERT_IMPL(a_cnt_range, 1'b1, used_q[0] <= CntW'(MaxLevels) && used_q[1] <= CntW'(MaxLevels), "level count overflow")
	`OBPL_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
endmodule

[dv/tb_order_book_price_levels.sv]
module tb_order_book_price_levels;
	timeunit 1ns;
	timeprecision 1ps;
	import obpl_pkg::*;

	// keeps a shadow copy of both book sides and the results still owed by the block
	class level_book_sb;
		bit [31:0]  lvl_price[2][MaxLevels];
		bit [31:0]  lvl_size[2][MaxLevels];
		bit [15:0]  lvl_orders[2][MaxLevels];
		int         lvl_used[2];
		bit [183:0] owed_results[$];
		int         mismatches;

		function int find_slot(int sd, bit [31:0] p);
			int lo, hi, m;
			bit better;
			lo = 0;
			hi = lvl_used[sd];
			while (lo < hi) begin
				m = lo + (hi - lo) / 2;
				better = (sd == 0) ? (lvl_price[sd][m] > p) : (lvl_price[sd][m] < p);
				if (better) lo = m + 1;
				else hi = m;
			end
			return lo;
		endfunction

		function bit [1:0] apply_update(int sd, bit [31:0] p, bit [31:0] qty, bit [15:0] o);
			int idx;
			idx = find_slot(sd, p);
			if (idx < lvl_used[sd] && lvl_price[sd][idx] == p) begin
				if (qty == 0) begin
					for (int i = idx; i + 1 < lvl_used[sd]; i++) begin
						lvl_price[sd][i] = lvl_price[sd][i+1];
						lvl_size[sd][i] = lvl_size[sd][i+1];
						lvl_orders[sd][i] = lvl_orders[sd][i+1];
					end
					lvl_used[sd]--;
				end else begin
					lvl_size[sd][idx] = qty;
					lvl_orders[sd][idx] = o;
				end
				return ST_OK;
			end
			if (qty == 0) return ST_OK;
			if (lvl_used[sd] >= MaxLevels) return ST_FULL;
			for (int i = lvl_used[sd]; i > idx; i--) begin
				lvl_price[sd][i] = lvl_price[sd][i-1];
				lvl_size[sd][i] = lvl_size[sd][i-1];
				lvl_orders[sd][i] = lvl_orders[sd][i-1];
			end
			lvl_price[sd][idx] = p;
			lvl_size[sd][idx] = qty;
			lvl_orders[sd][idx] = o;
			lvl_used[sd]++;
			return ST_OK;
		endfunction

		function void note_request(bit [95:0] d);
			bit [1:0]  req, st;
			int        sd, n, ws;
			bit [31:0] p, qty;
			bit [15:0] o;
			bit [6:0]  dep;
			bit [63:0] acc, left, fill;
			bit [31:0] bb, ba;
			bit [32:0] spr, mid;
			bit [37:0] q;
			req = d[1:0];
			sd = d[2];
			p = d[34:3];
			qty = d[66:35];
			o = d[82:67];
			dep = d[89:83];
			st = ST_OK;
			q = '0;
			case (req)
				REQ_UPDATE: st = apply_update(sd, p, qty, o);
				REQ_CLEAR: begin
					lvl_used[0] = 0;
					lvl_used[1] = 0;
				end
				REQ_VOLUME: begin
					n = (dep > 0 && dep < lvl_used[sd]) ? dep : lvl_used[sd];
					acc = 0;
					for (int i = 0; i < n; i++) acc += lvl_size[sd][i];
					q = (acc > 64'(VolMax)) ? VolMax : acc[37:0];
				end
				default: begin
					ws = (sd == 0) ? 1 : 0;
					if (qty != 0) begin
						left = qty;
						acc = 0;
						for (int i = 0; i < lvl_used[ws] && left > 0; i++) begin
							fill = (lvl_size[ws][i] < left) ? lvl_size[ws][i] : left;
							acc += fill * lvl_price[ws][i];
							left -= fill;
						end
						if (left > 0) st = ST_THIN;
						else q = 38'(acc / qty);
					end
				end
			endcase
			bb = lvl_used[0] > 0 ? lvl_price[0][0] : 0;
			ba = lvl_used[1] > 0 ? lvl_price[1][0] : 0;
			spr = '0;
			mid = '0;
			if (bb != 0 && ba != 0) begin
				spr = {1'b0, ba} - {1'b0, bb};
				mid = {1'b0, ba} + {1'b0, bb};
			end
			owed_results.push_back({q, 7'(lvl_used[1]), 7'(lvl_used[0]), mid, spr, ba, bb, st});
		endfunction

		function void cmp_field(string nm, bit [63:0] e, bit [63:0] a);
			if (e !== a) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch %s: expected %0h, got %0h", nm, e, a);
			end
		endfunction

		function void check_result(logic [183:0] a);
			bit [183:0] e;
			if (owed_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transaction %0h", a);
				return;
			end
			e = owed_results.pop_front();
			cmp_field("status", e[1:0], a[1:0]);
			cmp_field("best_bid_price", e[33:2], a[33:2]);
			cmp_field("best_ask_price", e[65:34], a[65:34]);
			cmp_field("spread", e[98:66], a[98:66]);
			cmp_field("mid_price_x2", e[131:99], a[131:99]);
			cmp_field("bid_level_count", e[138:132], a[138:132]);
			cmp_field("ask_level_count", e[145:139], a[145:139]);
			cmp_field("query_result", e[183:146], a[183:146]);
		endfunction
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [95:0]  s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [183:0] m_axis_tdata;

	level_book_sb sb = new();
	bit quiet = 0;
	bit hold_off_req = 0;

	order_book_price_levels i_dut (.*);

	always #10 clk = ~clk;

	initial begin
		#50ms;
		$display("RESULT: ERROR");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

	// result side: random stall bursts, one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				m_axis_tready = 0;
				repeat (600) @(negedge clk);
				hold_off_req = 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_axis_tready = 0;
				repeat ($urandom_range(1, 8) - 1) @(negedge clk);
			end else
				m_axis_tready = 1;
		end
	end

	task automatic send_req(bit [1:0] req, bit sd, bit [31:0] p, bit [31:0] qty,
			bit [15:0] o, bit [6:0] dep);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid = 0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		s_axis_tvalid = 1;
		s_axis_tdata = {6'd0, dep, o, qty, p, sd, req};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(s_axis_tdata);
		@(negedge clk);
	endtask

	task automatic send_random(int mode);
		int r, sd, k;
		bit [31:0] p, qty;
		r = $urandom_range(0, 99);
		sd = $urandom_range(0, 1);
		p = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(1000, 1150));
		if ($urandom_range(0, 9) == 0) qty = $urandom;
		else qty = $urandom_range(1, 1000);
		if (r < 1) send_req(REQ_CLEAR, 1'(sd), $urandom, $urandom, 16'($urandom),
			7'($urandom));
		else if (r < 12) send_req(REQ_VOLUME, 1'(sd), $urandom, $urandom, 16'($urandom),
			7'($urandom_range(0, 127)));
		else if (r < 25) begin
			if ($urandom_range(0, 7) == 0) qty = 0;
			else if ($urandom_range(0, 3) != 0) qty = $urandom_range(1, 5000);
			send_req(REQ_VWAP, 1'(sd), $urandom, qty, 16'($urandom), 7'($urandom));
		end else begin
			// shrinking deletes held levels, growing mostly inserts
			if (mode == 2 && sb.lvl_used[sd] > 0) begin
				k = $urandom_range(0, sb.lvl_used[sd] - 1);
				p = sb.lvl_price[sd][k];
				qty = 0;
			end else if (mode != 1 && $urandom_range(0, 6) == 0)
				qty = 0;
			else if (mode == 1 && $urandom_range(0, 2) == 0)
				qty = 0;
			send_req(REQ_UPDATE, 1'(sd), p, qty, 16'($urandom), 7'($urandom));
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// empty book queries
		send_req(REQ_VOLUME, 0, 0, 0, 0, 0);
		send_req(REQ_VWAP, 0, 0, 5, 0, 0);
		send_req(REQ_VWAP, 1, 0, 0, 0, 0);
		send_req(REQ_UPDATE, 0, 100, 0, 0, 0);
		// extremes of price, size and order count
		send_req(REQ_UPDATE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 7'h7F);
		send_req(REQ_UPDATE, 0, 1, 32'hFFFF_FFFF, 0, 0);
		send_req(REQ_UPDATE, 1, 0, 10, 1, 0);
		send_req(REQ_UPDATE, 1, 500, 20, 2, 0);
		send_req(REQ_UPDATE, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0);
		// crossed book; the zero best ask price forces spread and mid to zero
		send_req(REQ_VOLUME, 0, 0, 0, 0, 0);
		send_req(REQ_VOLUME, 1, 0, 0, 0, 1);
		send_req(REQ_VOLUME, 1, 0, 0, 0, 7'h7F);
		send_req(REQ_VWAP, 0, 0, 15, 0, 0);
		send_req(REQ_VWAP, 1, 0, 32'hFFFF_FFFF, 0, 0);
		send_req(REQ_VWAP, 0, 0, 32'hFFFF_FFFF, 0, 0);
		send_req(REQ_UPDATE, 0, 32'hFFFF_FFFF, 0, 0, 0);
		send_req(REQ_UPDATE, 1, 500, 7, 9, 0);
		send_req(REQ_UPDATE, 1, 0, 0, 0, 0);
		send_req(REQ_UPDATE, 1, 777, 0, 0, 0);
		send_req(REQ_CLEAR, 0, 0, 0, 0, 0);
		send_req(REQ_VOLUME, 1, 0, 0, 0, 0);
		// random phases: growing to a full side, mixed, shrinking
		for (int i = 0; i < 1450; i++) begin
			if (i == 700) hold_off_req = 1;
			if (i == 1300) quiet = 1;
			send_random((i / 150) % 3 == 1 ? 0 : ((i / 150) % 3 == 2 ? 2 : 1));
		end
		s_axis_tvalid = 0;
		while (sb.owed_results.size() != 0) @(posedge clk);
		repeat (300) @(negedge clk);
		if (sb.mismatches == 0 && sb.owed_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
